// ===== rtl/spt_pkg.sv =====
// ----------------------------------------------------------------------------
// spt_pkg
// Shared constants, codes and controller/datapath interface types for the
// sorted price level table.
// ----------------------------------------------------------------------------
package spt_pkg;

    localparam int CAPACITY    = 256;
    localparam int KEY_BITS    = 32;
    localparam int HANDLE_BITS = 16;

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);

    localparam int REQ_W    = 3;
    localparam int STATUS_W = 2;
    localparam int KEY_W    = 32;
    localparam int HDL_W    = 16;
    localparam int OCNT_W   = 9;

    localparam logic [REQ_W-1:0] REQ_FIND = 3'd0;
    localparam logic [REQ_W-1:0] REQ_INS  = 3'd1;
    localparam logic [REQ_W-1:0] REQ_REM  = 3'd2;
    localparam logic [REQ_W-1:0] REQ_MIN  = 3'd3;
    localparam logic [REQ_W-1:0] REQ_MAX  = 3'd4;

    localparam logic [STATUS_W-1:0] ST_DONE    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_ABSENT  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_PRESENT = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd3;

    typedef struct packed {
        logic                load;
        logic                rd_mid;
        logic                rd_lo;
        logic                cmp;
        logic                shift_init;
        logic                rd_shift;
        logic                wr_shift;
        logic                wr_new;
        logic                cnt_dec;
        logic                finish;
        logic                out_hdl;
        logic [STATUS_W-1:0] status;
    } t_cmd;

    typedef struct packed {
        logic             lo_lt_hi;
        logic             hit;
        logic             full;
        logic             empty;
        logic             shift_more;
        logic [REQ_W-1:0] req;
    } t_stat;

endpackage

// ===== rtl/spt_ctrl.sv =====
// ----------------------------------------------------------------------------
// spt_ctrl
// Sequencer for search, shift and write steps of each transaction.
// ----------------------------------------------------------------------------
module spt_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  spt_pkg::t_stat i_stat,
    output spt_pkg::t_cmd  o_cmd,
    output logic          o_busy
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SRD   = 3'd1;
    localparam logic [2:0] S_SCMP  = 3'd2;
    localparam logic [2:0] S_HIT   = 3'd3;
    localparam logic [2:0] S_SHCHK = 3'd4;
    localparam logic [2:0] S_SHWR  = 3'd5;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_SRD;
                end
            end
            S_SRD: begin
                if (i_stat.lo_lt_hi) begin
                    o_cmd.rd_mid = 1'b1;
                    n_state      = S_SCMP;
                end else begin
                    o_cmd.rd_lo = 1'b1;
                    n_state     = S_HIT;
                end
            end
            S_SCMP: begin
                o_cmd.cmp = 1'b1;
                n_state   = S_SRD;
            end
            S_HIT: begin
                n_state      = S_IDLE;
                o_cmd.finish = 1'b1;
                o_cmd.status = spt_pkg::ST_ABSENT;
                priority case (i_stat.req)
                    spt_pkg::REQ_FIND: begin
                        if (i_stat.hit) begin
                            o_cmd.status  = spt_pkg::ST_DONE;
                            o_cmd.out_hdl = 1'b1;
                        end
                    end
                    spt_pkg::REQ_INS: begin
                        if (i_stat.hit) begin
                            o_cmd.status = spt_pkg::ST_PRESENT;
                        end else if (i_stat.full) begin
                            o_cmd.status = spt_pkg::ST_FULL;
                        end else begin
                            o_cmd.finish     = 1'b0;
                            o_cmd.shift_init = 1'b1;
                            n_state          = S_SHCHK;
                        end
                    end
                    spt_pkg::REQ_REM: begin
                        if (i_stat.hit) begin
                            o_cmd.finish     = 1'b0;
                            o_cmd.shift_init = 1'b1;
                            n_state          = S_SHCHK;
                        end
                    end
                    spt_pkg::REQ_MIN, spt_pkg::REQ_MAX: begin
                        if (!i_stat.empty) begin
                            o_cmd.status  = spt_pkg::ST_DONE;
                            o_cmd.out_hdl = 1'b1;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            S_SHCHK: begin
                if (i_stat.shift_more) begin
                    o_cmd.rd_shift = 1'b1;
                    n_state        = S_SHWR;
                end else begin
                    o_cmd.finish = 1'b1;
                    o_cmd.status = spt_pkg::ST_DONE;
                    if (i_stat.req == spt_pkg::REQ_INS) begin
                        o_cmd.wr_new = 1'b1;
                    end else begin
                        o_cmd.cnt_dec = 1'b1;
                    end
                    n_state = S_IDLE;
                end
            end
            S_SHWR: begin
                o_cmd.wr_shift = 1'b1;
                n_state        = S_SHCHK;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

// ===== rtl/spt_datapath.sv =====
// ----------------------------------------------------------------------------
// spt_datapath
// Sorted key and handle memories, search bounds, shift index, entry count
// and result registers.
// ----------------------------------------------------------------------------
module spt_datapath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  spt_pkg::t_cmd                 i_cmd,
    input  logic [spt_pkg::REQ_W-1:0]     i_req_type,
    input  logic [spt_pkg::KEY_W-1:0]     i_price_key,
    input  logic [spt_pkg::HDL_W-1:0]     i_level_handle_in,
    output spt_pkg::t_stat                o_stat,
    output logic                          o_valid,
    output logic [spt_pkg::STATUS_W-1:0]  o_status,
    output logic [spt_pkg::HDL_W-1:0]     o_level_handle_out,
    output logic [spt_pkg::OCNT_W-1:0]    o_entry_count
);

    localparam int KB = spt_pkg::KEY_BITS;
    localparam int HB = spt_pkg::HANDLE_BITS;
    localparam int IW = spt_pkg::IDX_W;
    localparam int CW = spt_pkg::CNT_W;
    localparam logic [CW-1:0] CAP = CW'(spt_pkg::CAPACITY);
    localparam logic [CW-1:0] ONE = CW'(1);

    logic [KB-1:0] key_mem [spt_pkg::CAPACITY];
    logic [HB-1:0] hdl_mem [spt_pkg::CAPACITY];

    logic [spt_pkg::REQ_W-1:0] r_req;
    logic [KB-1:0]             r_key;
    logic [HB-1:0]             r_hin;
    logic [CW-1:0]             r_lo;
    logic [CW-1:0]             r_hi;
    logic [CW-1:0]             r_idx;
    logic [CW-1:0]             r_count;
    logic [CW-1:0]             n_count;
    logic [KB-1:0]             r_rkey;
    logic [HB-1:0]             r_rhdl;
    logic                      r_valid;
    logic [spt_pkg::STATUS_W-1:0] r_status;
    logic [spt_pkg::HDL_W-1:0]    r_hout;
    logic [CW-1:0]             mid;
    logic                      rd_en;
    logic [IW-1:0]             rd_addr;
    logic                      wr_en;
    logic [IW-1:0]             wr_addr;
    logic [KB-1:0]             wr_key;
    logic [HB-1:0]             wr_hdl;
    logic                      is_ins;

    assign mid    = r_lo + ((r_hi - r_lo) >> 1);
    assign is_ins = (r_req == spt_pkg::REQ_INS);

    always_comb begin
        rd_en   = i_cmd.rd_mid | i_cmd.rd_lo | i_cmd.rd_shift;
        rd_addr = r_lo[IW-1:0];
        if (i_cmd.rd_mid) begin
            rd_addr = mid[IW-1:0];
        end else if (i_cmd.rd_shift) begin
            rd_addr = is_ins ? IW'(r_idx - ONE) : IW'(r_idx + ONE);
        end
        wr_en   = i_cmd.wr_shift | i_cmd.wr_new;
        wr_addr = i_cmd.wr_new ? r_lo[IW-1:0] : r_idx[IW-1:0];
        wr_key  = i_cmd.wr_new ? r_key : r_rkey;
        wr_hdl  = i_cmd.wr_new ? r_hin : r_rhdl;
        n_count = r_count;
        if (i_cmd.wr_new) begin
            n_count = r_count + ONE;
        end else if (i_cmd.cnt_dec) begin
            n_count = r_count - ONE;
        end
    end

    // memories
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            key_mem[wr_addr] <= wr_key;
            hdl_mem[wr_addr] <= wr_hdl;
        end
        if (rd_en) begin
            r_rkey <= key_mem[rd_addr];
            r_rhdl <= hdl_mem[rd_addr];
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req <= i_req_type;
            r_key <= i_price_key[KB-1:0];
            r_hin <= i_level_handle_in[HB-1:0];
            if (i_req_type == spt_pkg::REQ_FIND || i_req_type == spt_pkg::REQ_INS ||
                i_req_type == spt_pkg::REQ_REM) begin
                r_lo <= '0;
                r_hi <= r_count;
            end else if (i_req_type == spt_pkg::REQ_MAX && r_count != '0) begin
                r_lo <= r_count - ONE;
                r_hi <= r_count - ONE;
            end else begin
                r_lo <= '0;
                r_hi <= '0;
            end
        end else if (i_cmd.cmp) begin
            if (r_rkey < r_key) begin
                r_lo <= mid + ONE;
            end else begin
                r_hi <= mid;
            end
        end
        if (i_cmd.shift_init) begin
            r_idx <= is_ins ? r_count : r_lo;
        end else if (i_cmd.wr_shift) begin
            r_idx <= is_ins ? r_idx - ONE : r_idx + ONE;
        end
        if (i_cmd.finish) begin
            r_status <= i_cmd.status;
            r_hout   <= i_cmd.out_hdl ? spt_pkg::HDL_W'(r_rhdl) : '0;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            r_valid <= i_cmd.finish;
        end
    end

    assign o_stat.lo_lt_hi   = (r_lo < r_hi);
    assign o_stat.hit        = (r_lo < r_count) && (r_rkey == r_key);
    assign o_stat.full       = (r_count >= CAP);
    assign o_stat.empty      = (r_count == '0);
    assign o_stat.shift_more = is_ins ? (r_idx > r_lo) : ((r_idx + ONE) < r_count);
    assign o_stat.req        = r_req;

    assign o_valid            = r_valid;
    assign o_status           = r_status;
    assign o_level_handle_out = r_hout;
    assign o_entry_count      = spt_pkg::OCNT_W'(r_count);

    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CAP) else $error("entry count above capacity");
    a_no_write_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.wr_new |-> r_count < CAP) else $error("insert into full table");
    a_dec_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.cnt_dec |-> r_count != '0) else $error("remove from empty table");

endmodule

// ===== rtl/sorted_price_level_table_core.sv =====
// ----------------------------------------------------------------------------
// sorted_price_level_table_core
// Ordered map from price key to level handle with find, insert, remove,
// minimum and maximum requests.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. Its result appears
// on o_status, o_level_handle_out and o_entry_count for one cycle with
// o_valid high; the receiver cannot stall it. Entries sit in ascending key
// order in single-port-per-cycle memories. Find, insert and remove run a
// binary search, each probe a read step then a compare step; minimum and
// maximum read the first or last entry. An insert or remove then moves each
// entry above the position one slot, a read then a write per moved entry;
// an insert ends by writing the new entry, via the one read and write port.
// Busy is high from the cycle after acceptance until the result strobe.
module sorted_price_level_table_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [spt_pkg::REQ_W-1:0]     i_req_type,
    input  logic [spt_pkg::KEY_W-1:0]     i_price_key,
    input  logic [spt_pkg::HDL_W-1:0]     i_level_handle_in,
    output logic                          o_valid,
    output logic [spt_pkg::STATUS_W-1:0]  o_status,
    output logic [spt_pkg::HDL_W-1:0]     o_level_handle_out,
    output logic [spt_pkg::OCNT_W-1:0]    o_entry_count
);

    spt_pkg::t_cmd  cmd;
    spt_pkg::t_stat stat;
    logic           go;

    assign go = start & ~busy;

    spt_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (go),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    spt_datapath u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (cmd),
        .i_req_type         (i_req_type),
        .i_price_key        (i_price_key),
        .i_level_handle_in  (i_level_handle_in),
        .o_stat             (stat),
        .o_valid            (o_valid),
        .o_status           (o_status),
        .o_level_handle_out (o_level_handle_out),
        .o_entry_count      (o_entry_count)
    );

    a_busy_after_go: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        go |=> busy) else $error("not busy after transaction accepted");
    a_idle_at_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy) else $error("busy during result strobe");
    a_zero_handle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != spt_pkg::ST_DONE) |-> o_level_handle_out == '0)
        else $error("nonzero handle on failed transaction");

endmodule
